[design/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // front to back queue entry
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_item_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[design/sha256_queue.sv]
// ----------------------------------------------------------------------------
// sha256_queue
// Small two-entry queue between the input front and the hashing back end.
// ----------------------------------------------------------------------------
module sha256_queue
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sha_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output sha_item_t out_item
);

  sha_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];

  // pointer and fill bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_valid && out_ready) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

[design/sha256_engine.sv]
// ----------------------------------------------------------------------------
// sha256_engine
// Back end: collects bytes into the block, pads, runs 64 rounds per block
// and streams the eight digest words out through an output register.
// ----------------------------------------------------------------------------
module sha256_engine
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  sha_item_t   item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        final_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROUND, S_PAD, S_LEN, S_EMIT
  } state_t;

  state_t      state;
  logic [63:0] bit_count;
  logic [63:0] len_snap;
  logic [31:0] window [16];  // block words while filling, then rolling schedule
  logic [31:0] chain [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0]  round;
  logic        after_last;   // compression belongs to padding phase
  logic        second_pad;   // one more padding block follows
  logic        len_done;     // length words written, next compression is the last
  logic [2:0]  emit_idx;

  logic [5:0]  pos;
  logic [31:0] w_cur, w_new, t1, t2, s1e, s0a, chv, mjv;

  assign pos        = bit_count[8:3];
  assign item_ready = (state == S_IDLE);

  // schedule and round datapath
  always_comb begin
    w_new = window[0] + sig0(window[1]) + window[9] + sig1(window[14]);
    w_cur = (round < 6'd16) ? window[round[3:0]] : w_new;
    s1e   = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    chv   = (e & f) ^ (~e & g);
    t1    = h + s1e + chv + ROUND_K[round] + w_cur;
    s0a   = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    mjv   = (a & b) ^ (a & c) ^ (b & c);
    t2    = s0a + mjv;
  end

  // control, block words and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bit_count  <= '0;
      after_last <= 1'b0;
      second_pad <= 1'b0;
      len_done   <= 1'b0;
      out_valid  <= 1'b0;
      emit_idx   <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= H_INIT[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.has_byte) begin
              window[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= item.data_byte;
              bit_count <= bit_count + 64'd8;
            end
            after_last <= item.end_of_message;
            if (item.has_byte && pos == 6'd63) begin
              state <= S_LOAD;
            end else if (item.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // 0x80 at fill position, clear to block end
          for (int k = 0; k < 16; k++) begin
            for (int l = 0; l < 4; l++) begin
              if (6'(4*k + l) == pos) begin
                window[k][31 - 8*l -: 8] <= PAD_BYTE;
              end else if (6'(4*k + l) > pos) begin
                window[k][31 - 8*l -: 8] <= 8'h00;
              end
            end
          end
          len_snap   <= bit_count;
          second_pad <= (pos >= 6'd56);
          state      <= (pos >= 6'd56) ? S_LOAD : S_LEN;
        end
        S_LEN: begin
          // extra length-only block starts from zero words
          if (second_pad) begin
            for (int k = 0; k < 14; k++) window[k] <= '0;
            second_pad <= 1'b0;
          end
          window[14] <= len_snap[63:32];
          window[15] <= len_snap[31:0];
          len_done   <= 1'b1;
          state      <= S_LOAD;
        end
        S_LOAD: begin
          {a, b, c, d, e, f, g, h} <= {chain[0], chain[1], chain[2], chain[3],
                                       chain[4], chain[5], chain[6], chain[7]};
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (round >= 6'd16) begin
            for (int j = 0; j < 15; j++) window[j] <= window[j+1];
            window[15] <= w_new;
          end
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) begin
            chain[0] <= chain[0] + t1 + t2;
            chain[1] <= chain[1] + a;
            chain[2] <= chain[2] + b;
            chain[3] <= chain[3] + c;
            chain[4] <= chain[4] + d + t1;
            chain[5] <= chain[5] + e;
            chain[6] <= chain[6] + f;
            chain[7] <= chain[7] + g;
            if (!after_last) begin
              state <= S_IDLE;
            end else if (second_pad) begin
              state <= S_LEN;
            end else if (!len_done) begin
              state <= S_PAD;
            end else begin
              state    <= S_EMIT;
              emit_idx <= '0;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            digest_word <= chain[emit_idx];
            word_index  <= emit_idx;
            final_word  <= (emit_idx == 3'd7);
            emit_idx    <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              state      <= S_IDLE;
              bit_count  <= '0;
              after_last <= 1'b0;
              len_done   <= 1'b0;
              for (int i = 0; i < 8; i++) chain[i] <= H_INIT[i];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_EMIT)) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/sha256_message_hasher_core.sv]
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// SHA-256 of a byte stream; eight digest words per message.
//
//   channel | handshake          | payload
//   in      | in_valid/in_ready  | data_byte, has_byte, end_of_message
//   out     | out_valid/out_ready| digest_word, word_index, final_word
//
// The back end accepts byte items while idle; the 64th byte of a block adds
// a load step and 64 rounds of the single round unit.
// The last item adds padding, one or two compressions, then eight digest
// transfers.
// Reset restores the initial hash values; no clearing pass.
// A two-entry queue lets up to two input transfers complete while the back end is busy.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        final_word
);

  sha_item_t in_item, q_item;
  logic      q_valid, q_ready;

  assign in_item = '{data_byte: data_byte, has_byte: has_byte,
                     end_of_message: end_of_message};

  // front queue
  sha256_queue u_queue (
    .clk, .rst,
    .in_valid, .in_ready, .in_item,
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  // hashing back end
  sha256_engine u_engine (
    .clk, .rst,
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid, .out_ready, .digest_word, .word_index, .final_word
  );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream SHA-256 hasher: directed and random messages are sent one byte
// per transfer and each digest word is checked against a built-in hash model.
// ----------------------------------------------------------------------------
module tb_top;
  import sha256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_exp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;

  // model state
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [63:0] bit_count;

  digest_exp_t digest_q[$];
  int          n_err = 0;
  int          n_items = 0;
  int          n_words = 0;
  int          n_msgs = 0;
  int          idle_cnt = 0;
  bit          hold_rx = 1'b0;
  bit          done = 1'b0;

  always #2 clk = ~clk;

  sha256_message_hasher_core u_dut (.*);

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of blk into chain
  task automatic compress_blk();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wr, t1, t2, s0, s1, wa, wb;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        wa = w[(r - 15) & 15];
        wb = w[(r - 2) & 15];
        s0 = ror32(wa, 7) ^ ror32(wa, 18) ^ (wa >> 3);
        s1 = ror32(wb, 17) ^ ror32(wb, 19) ^ (wb >> 10);
        wr = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
        w[r & 15] = wr;
      end
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
  endtask

  task automatic restart_hash();
    for (int j = 0; j < 8; j++) chain[j] = H_INIT[j];
    bit_count = '0;
  endtask

  // predict the digest words caused by one accepted item
  task automatic predict_digest(logic [7:0] b, logic hb, logic eom);
    int pos;
    logic [63:0] bits;
    digest_exp_t e;
    if (hb) begin
      pos = bit_count[8:3];
      blk[pos] = b;
      bit_count += 64'd8;
      if (pos == 63) compress_blk();
    end
    if (!eom) return;
    bits = bit_count;
    pos = bits[8:3];
    blk[pos] = PAD_BYTE;
    if (pos >= 56) begin
      for (int j = pos + 1; j < 64; j++) blk[j] = 8'h00;
      compress_blk();
      for (int j = 0; j < 56; j++) blk[j] = 8'h00;
    end else begin
      for (int j = pos + 1; j < 56; j++) blk[j] = 8'h00;
    end
    for (int j = 0; j < 8; j++) blk[56 + j] = bits[63 - 8*j -: 8];
    compress_blk();
    for (int j = 0; j < 8; j++) begin
      e.word = chain[j];
      e.idx = j[2:0];
      e.fin = (j == 7);
      digest_q.insert(digest_q.size(), e);
    end
    n_msgs++;
    restart_hash();
  endtask

  // send one item, random gap before it
  task automatic send_item(logic [7:0] b, logic hb, logic eom);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= hb;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    predict_digest(b, hb, eom);
    n_items++;
  endtask

  task automatic send_msg(int len, bit noise, bit eom_on_byte);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 7) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, eom_on_byte && (i == len - 1));
    end
    if (!eom_on_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  // empty message, ignored items, extreme byte values
  task automatic test_empty_and_ignored();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b1);
  endtask

  // padding boundaries: 55, 56 and 64 byte messages
  task automatic test_pad_boundaries();
    send_msg(55, 1'b0, 1'b1);
    send_msg(56, 1'b0, 1'b0);
    send_msg(64, 1'b0, 1'b1);
  endtask

  // receiver held off while the sender keeps going
  task automatic test_backpressure();
    hold_rx = 1'b1;
    send_msg(3, 1'b0, 1'b1);
    send_msg(2, 1'b0, 1'b1);
    send_msg(1, 1'b0, 1'b0);
    hold_rx = 1'b0;
  endtask

  task automatic test_random_msgs();
    int len;
    while (n_items < 215) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(50, 70);
        default: len = $urandom_range(0, 30);
      endcase
      if (len > 220 - n_items) len = 220 - n_items;
      send_msg(len, 1'b1, 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver: random stalls, one long hold when asked
  initial begin
    int hold_cnt;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < 300) begin
          @(posedge clk);
          hold_cnt++;
        end
      end else begin
        if (!hold_rx) held = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
          repeat ($urandom_range(0, 3)) @(posedge clk);
        end
      end
    end
  end

  // digest word checker
  always @(posedge clk) begin
    digest_exp_t e;
    if (!rst && out_valid && out_ready) begin
      n_words++;
      if (digest_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected digest word %h idx %0d", digest_word, word_index);
      end else begin
        e = digest_q.pop_front();
        if (digest_word !== e.word || word_index !== e.idx || final_word !== e.fin) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", e.word, e.idx, e.fin,
                     digest_word, word_index, final_word);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || done) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    restart_hash();
    for (int j = 0; j < 64; j++) blk[j] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_ignored();
    test_pad_boundaries();
    test_backpressure();
    test_random_msgs();
    wait_drain();
    done = 1'b1;
    $display("sent %0d items in %0d messages, checked %0d digest words",
             n_items, n_msgs, n_words);
    if (n_err == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[filelist.f]
design/sha256_pkg.sv
design/sha256_queue.sv
design/sha256_engine.sv
design/sha256_message_hasher_core.sv
tb/tb_top.sv
